// ----- rtl/blake2b_hash_engine_defines.svh -----
// Assertion macros used by the top-level engine file.
`ifndef BLAKE2B_HASH_ENGINE_DEFINES_SVH
`define BLAKE2B_HASH_ENGINE_DEFINES_SVH
// Asserts that a condition implies a property in the same cycle.
`define B2B_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Asserts that a condition implies a property in the next cycle.
`define B2B_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/b2b_pkg.sv -----
package b2b_pkg;

  typedef struct packed {
    logic [63:0] msg_word;
    logic        last;
    logic [3:0]  last_bytes;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [3:0]  digest_bytes;
    logic        digest_last;
  } out_item_t;

  // Classified work handed from the front to the back.
  typedef struct packed {
    logic [63:0] word;
    logic        has_word;
    logic        is_last;
    logic [3:0]  nbytes;
  } cmd_t;

  localparam logic [63:0] PARAM_BASE = 64'h0000_0000_0101_0000;
  localparam logic [63:0] FINAL_FLAG = 64'hffff_ffff_ffff_ffff;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  // State-vector indices a, b, c, d for each of the eight G calls of a round.
  localparam logic [3:0] LANE [8][4] = '{
    '{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd1, 4'd5, 4'd9, 4'd13},
    '{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15},
    '{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
    '{4'd2, 4'd7, 4'd8, 4'd13}, '{4'd3, 4'd4, 4'd9, 4'd14}
  };

  function automatic logic [6:0] eff_len(input logic [6:0] len);
    if (len == 7'd0) return 7'd1;
    if (len > 7'd64) return 7'd64;
    return len;
  endfunction

endpackage

// ----- rtl/b2b_front.sv -----
module b2b_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  b2b_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output b2b_pkg::cmd_t     cmd
);
  import b2b_pkg::*;

  cmd_t        cls;
  logic [3:0]  nb;
  logic [63:0] mask;

  always_comb begin
    nb = in_data.last ? ((in_data.last_bytes > 4'd8) ? 4'd8 : in_data.last_bytes) : 4'd8;
    mask = (nb == 4'd8) ? '1 : ((64'd1 << {nb[2:0], 3'b000}) - 64'd1);
    cls.word = in_data.msg_word & mask;
    cls.has_word = (nb != 4'd0);
    cls.is_last = in_data.last;
    cls.nbytes = nb;
  end

  // Two-entry queue decouples classification from compression.
  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) q_r[wp_r] <= cls;
  end
endmodule

// ----- rtl/b2b_back.sv -----
module b2b_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  b2b_pkg::cmd_t      cmd,
  input  logic               cfg_valid,
  input  logic [6:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output b2b_pkg::out_item_t out_data,
  output logic               busy
);
  import b2b_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_ROUND, S_FIN, S_EMIT, S_PAD
  } state_t;

  state_t      state_r;
  logic [63:0] mblk_r [16];
  logic [63:0] h_r [8];
  logic [63:0] v_r [16];
  logic [4:0]  fill_r;
  logic [63:0] cnt_r;
  logic [6:0]  len_r;
  logic [3:0]  rnd_r;
  logic [3:0]  rsel_r;
  logic [2:0]  gi_r;
  logic        half_r;
  logic        final_r;
  logic [2:0]  ok_r;
  cmd_t        pend_r;
  out_item_t   od_r;
  logic        ov_r;

  logic [6:0]  el;
  logic [2:0]  nw_m1;
  logic [3:0]  ia, ib, ic, id;
  logic [63:0] x, a1, d1, c1, b1;

  assign el        = eff_len(len_r);
  assign nw_m1     = 3'((el - 7'd1) >> 3);
  assign cmd_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign busy      = (state_r != S_IDLE) || ov_r;

  // One half of a G function per cycle on the state vector.
  always_comb begin
    ia = LANE[gi_r][0];
    ib = LANE[gi_r][1];
    ic = LANE[gi_r][2];
    id = LANE[gi_r][3];
    x  = mblk_r[SIGMA[rsel_r][{gi_r, half_r}]];
    a1 = v_r[ia] + v_r[ib] + x;
    d1 = v_r[id] ^ a1;
    d1 = half_r ? {d1[15:0], d1[63:16]} : {d1[31:0], d1[63:32]};
    c1 = v_r[ic] + d1;
    b1 = v_r[ib] ^ c1;
    b1 = half_r ? {b1[62:0], b1[63]} : {b1[23:0], b1[63:24]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= 5'd0;
      cnt_r   <= '0;
      len_r   <= 7'd64;
      ov_r    <= 1'b0;
      for (int k = 0; k < 8; k++) h_r[k] <= IV[k];
      h_r[0]  <= IV[0] ^ PARAM_BASE ^ 64'd64;
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_data;
        if (fill_r == 5'd0 && cnt_r == '0)
          h_r[0] <= IV[0] ^ PARAM_BASE ^ {57'd0, eff_len(cfg_data)};
      end
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid && !ov_r) begin
            pend_r <= cmd;
            if (cmd.has_word && fill_r[4]) begin
              final_r <= 1'b0;
              state_r <= S_INIT;
            end else if (cmd.has_word) begin
              mblk_r[fill_r[3:0]] <= cmd.word;
              fill_r <= fill_r + 5'd1;
              cnt_r  <= cnt_r + {60'd0, cmd.nbytes};
              if (cmd.is_last) state_r <= S_PAD;
            end else begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // Zero the unused tail one word per cycle, then compress as final.
          if (fill_r[4]) begin
            final_r <= 1'b1;
            state_r <= S_INIT;
          end else begin
            mblk_r[fill_r[3:0]] <= '0;
            fill_r <= fill_r + 5'd1;
          end
        end
        S_INIT: begin
          for (int k = 0; k < 8; k++) begin
            v_r[k]   <= h_r[k];
            v_r[k+8] <= IV[k];
          end
          v_r[12] <= IV[4] ^ cnt_r;
          v_r[14] <= IV[6] ^ (final_r ? FINAL_FLAG : '0);
          v_r[15] <= IV[7] ^ (final_r ? FINAL_FLAG : '0);
          rnd_r   <= 4'd0;
          rsel_r  <= 4'd0;
          gi_r    <= 3'd0;
          half_r  <= 1'b0;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          v_r[ia] <= a1;
          v_r[id] <= d1;
          v_r[ic] <= c1;
          v_r[ib] <= b1;
          half_r  <= ~half_r;
          if (half_r) begin
            gi_r <= gi_r + 3'd1;
            if (gi_r == 3'd7) begin
              rnd_r  <= rnd_r + 4'd1;
              rsel_r <= (rsel_r == 4'd9) ? 4'd0 : rsel_r + 4'd1;
              if (rnd_r == 4'd11) state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          for (int k = 0; k < 8; k++) h_r[k] <= h_r[k] ^ v_r[k] ^ v_r[k+8];
          ok_r <= 3'd0;
          if (final_r) begin
            state_r <= S_EMIT;
          end else begin
            // The pending word opens the next block.
            mblk_r[0] <= pend_r.word;
            fill_r    <= 5'd1;
            cnt_r     <= cnt_r + {60'd0, pend_r.nbytes};
            state_r   <= pend_r.is_last ? S_PAD : S_IDLE;
          end
        end
        S_EMIT: begin
          if (!ov_r || out_ready) begin
            ov_r <= 1'b1;
            od_r.digest_word  <= h_r[ok_r];
            od_r.digest_last  <= (ok_r == nw_m1);
            od_r.digest_bytes <= (ok_r == nw_m1) ? 4'(el - {1'b0, ok_r, 3'b000}) : 4'd8;
            ok_r <= ok_r + 3'd1;
            if (ok_r == nw_m1) begin
              fill_r <= 5'd0;
              cnt_r  <= '0;
              for (int k = 0; k < 8; k++) h_r[k] <= IV[k];
              h_r[0] <= IV[0] ^ PARAM_BASE ^ {57'd0, el};
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/blake2b_hash_engine.sv -----
// Channel | Dir | Handshake           | Payload
// in_     | in  | in_valid/in_ready   | in_data (msg_word, last, last_bytes)
// out_    | out | out_valid/out_ready | out_data (digest_word, bytes, last)
// cfg_    | in  | cfg_valid/cfg_ready | cfg_data (digest_length)
// A word that lands in a free buffer slot is simply stored. A word that follows
// a full block starts a compression: take, setup, G halves for 12 rounds, fold.
// The last word adds zero padding of the block tail and a final compression,
// then one digest word per cycle while out_ready is high.
// Synchronous active-low reset; a two-entry queue lets input continue while
// the back end stalls on a full output register.
module blake2b_hash_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  b2b_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output b2b_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);
  import b2b_pkg::*;
  `include "blake2b_hash_engine_defines.svh"

  logic  cmd_valid, cmd_ready, busy;
  cmd_t  cmd;

  assign cfg_ready = 1'b1;

  b2b_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cmd_valid, .cmd_ready, .cmd
  );

  b2b_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .cfg_valid, .cfg_data,
    .out_valid, .out_ready, .out_data, .busy
  );

  `B2B_ASSERT_IMP(a_bytes_range, out_valid,
    out_data.digest_bytes >= 4'd1 && out_data.digest_bytes <= 4'd8)
  `B2B_ASSERT_IMP(a_short_is_last, out_valid && out_data.digest_bytes != 4'd8,
    out_data.digest_last)
  `B2B_ASSERT_IMP(a_no_take_when_busy, busy, !cmd_ready)
  `B2B_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import b2b_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_data = 7'd64;

  blake2b_hash_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  localparam logic [63:0] HASH_IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };
  localparam logic [63:0] LEN_PARAM = 64'h0101_0000;
  localparam logic [63:0] LAST_BLOCK = 64'hffff_ffff_ffff_ffff;
  localparam int PERM [10][16] = '{
    '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
    '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
    '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
    '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
    '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
    '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
    '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
    '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
    '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
    '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}
  };
  localparam int QUAD [8][4] = '{
    '{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
    '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14}
  };

  // Shadow state of the hash engine.
  logic [6:0] len_reg;
  logic [63:0] hstate [8];
  logic [63:0] blk [16];
  int fill;
  logic [63:0] nbytes_seen;

  out_item_t digest_q[$];
  int errors = 0;
  int mismatches = 0;
  int send_idle = 16;
  int recv_idle = 49;
  bit hold_recv = 1'b0;
  int cycles = 0;

  function automatic int clamp_len(logic [6:0] l);
    if (l == 7'd0) return 1;
    if (l > 7'd64) return 64;
    return int'(l);
  endfunction

  function automatic logic [63:0] ror(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic reset_chain();
    for (int k = 0; k < 8; k++) hstate[k] = HASH_IV[k];
    hstate[0] ^= LEN_PARAM | 64'(clamp_len(len_reg));
  endtask

  task automatic compress_block(logic [63:0] flag);
    logic [63:0] v [16];
    int a, b, c, d;
    logic [63:0] x, y;
    for (int k = 0; k < 8; k++) begin
      v[k] = hstate[k];
      v[k + 8] = HASH_IV[k];
    end
    v[12] ^= nbytes_seen;
    v[14] ^= flag;
    v[15] ^= flag;
    for (int r = 0; r < 12; r++) begin
      for (int g = 0; g < 8; g++) begin
        a = QUAD[g][0]; b = QUAD[g][1]; c = QUAD[g][2]; d = QUAD[g][3];
        x = blk[PERM[r % 10][2 * g]];
        y = blk[PERM[r % 10][2 * g + 1]];
        v[a] = v[a] + v[b] + x;
        v[d] = ror(v[d] ^ v[a], 32);
        v[c] = v[c] + v[d];
        v[b] = ror(v[b] ^ v[c], 24);
        v[a] = v[a] + v[b] + y;
        v[d] = ror(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = ror(v[b] ^ v[c], 63);
      end
    end
    for (int k = 0; k < 8; k++) hstate[k] ^= v[k] ^ v[k + 8];
  endtask

  task automatic predict_word(in_item_t it);
    logic [63:0] w;
    int nb, len, nw;
    out_item_t o;
    w = it.msg_word;
    nb = (it.last_bytes > 4'd8) ? 8 : int'(it.last_bytes);
    if (!it.last || nb > 0) begin
      if (fill >= 16) begin
        compress_block('0);
        fill = 0;
      end
      if (it.last && nb < 8) w &= (64'd1 << (8 * nb)) - 64'd1;
      blk[fill] = w;
      fill++;
      nbytes_seen += it.last ? 64'(nb) : 64'd8;
    end
    if (it.last) begin
      for (int k = fill; k < 16; k++) blk[k] = '0;
      compress_block(LAST_BLOCK);
      len = clamp_len(len_reg);
      nw = (len + 7) / 8;
      for (int k = 0; k < nw; k++) begin
        o.digest_word = hstate[k];
        o.digest_bytes = (k + 1 < nw) ? 4'd8 : 4'(len - 8 * k);
        o.digest_last = (k + 1 == nw);
        digest_q.push_back(o);
      end
      fill = 0;
      nbytes_seen = '0;
      reset_chain();
    end
  endtask

  task automatic send_word(logic [63:0] w, logic lst, logic [3:0] nb);
    in_item_t it;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.msg_word = w; it.last = lst; it.last_bytes = nb;
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_word(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Only used while idle, so the shadow chain follows the register at once.
  task automatic write_length(logic [6:0] l);
    cfg_data <= l;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    len_reg = l;
    if (fill == 0 && nbytes_seen == 0) reset_chain();
    @(posedge clk);
  endtask

  task automatic send_message(int nwords, int tail);
    for (int k = 0; k < nwords; k++) send_word({$urandom, $urandom}, 1'b0, 4'($urandom));
    send_word({$urandom, $urandom}, 1'b1, 4'(tail));
  endtask

  task automatic test_directed();
    send_word('0, 1'b1, 4'd0);
    send_word('1, 1'b1, 4'd8);
    send_word('1, 1'b1, 4'd1);
    send_word(64'h0011_2233_4455_6677, 1'b1, 4'd15);
    send_word('1, 1'b1, 4'd9);
    for (int k = 0; k < 16; k++) send_word('1, 1'b0, 4'd5);
    send_word('0, 1'b1, 4'd0);
    send_message(16, 3);
    drain();
  endtask

  task automatic test_lengths();
    logic [6:0] lens [7] = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd9, 7'd32, 7'd8};
    foreach (lens[i]) begin
      write_length(lens[i]);
      send_message($urandom_range(2), $urandom_range(8));
      drain();
    end
    write_length(7'd64);
  endtask

  task automatic test_random(int nitems);
    int n, tail, nw;
    n = 0;
    while (n < nitems) begin
      tail = $urandom_range(15);
      if ($urandom_range(9) == 0) begin
        write_length(7'($urandom_range(127)));
      end
      // Mostly short messages, a few spanning several blocks.
      nw = ($urandom_range(9) == 0) ? 40 : $urandom_range(6);
      n += 1 + nw;
      send_message(nw, tail);
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_recv = 1'b1;
    for (int k = 0; k < 6; k++) send_message(0, 8);
    in_valid <= 1'b0;
    while (hold_recv) @(posedge clk);
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_recv) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Long receiver hold-off counted in cycles of its own.
  always @(posedge clk) begin
    if (hold_recv) begin
      repeat (2000) @(posedge clk);
      hold_recv <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected digest word %h", out_data);
        mismatches++;
      end else begin
        e = digest_q.pop_front();
        if (out_data !== e) begin
          errors++;
          if (mismatches < 10) begin
            $display("digest mismatch: exp word %h bytes %0d last %0d",
                     e.digest_word, e.digest_bytes, e.digest_last);
            $display("                 got word %h bytes %0d last %0d",
                     out_data.digest_word, out_data.digest_bytes, out_data.digest_last);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    len_reg = 7'd64;
    fill = 0;
    nbytes_seen = '0;
    reset_chain();
    for (int k = 0; k < 16; k++) blk[k] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_lengths();
    test_random(70);
    send_idle = 49;
    recv_idle = 16;
    test_random(70);
    send_idle = 0;
    recv_idle = 0;
    test_backpressure();
    test_random(65);
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
